// ===== rtl/core/stzf_pkg.sv =====
// Package for the slice translation block: payload types, register indexes
// and default sizes. No dependencies.
package stzf_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int POS_BITS      = 9;
    localparam int PIX_BITS      = 16;
    localparam int DIM_BITS      = 10;
    localparam int SHIFT_BITS    = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;

    // signed coordinate wide enough for position - shift and the largest slice size
    localparam int COORD_BITS = 14;
    typedef logic signed [COORD_BITS-1:0] t_coord;

    localparam logic [DIM_BITS-1:0]   DIM_RESET   = DIM_BITS'(512);
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = '0;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SLICE_WIDTH,
        CFG_SLICE_HEIGHT,
        CFG_SHIFT_X,
        CFG_SHIFT_Y
    } t_cfg_idx;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [POS_BITS-1:0] col;
        logic [POS_BITS-1:0] row;
        logic [PIX_BITS-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_out;
        logic                from_source;
    } t_out_item;

endpackage

// ===== rtl/core/slice_translate_zero_fill.sv =====
// Slice translation with zero fill; uses stzf_pkg and stzf_ram.
// A fetch beat passes the bounds register, the slice RAM read and the output register
// in that order. Throughput: one beat per cycle, stores and fetches alike, set by the
// single RAM port pair, while the output is not stalled.
// Reset: pipeline valids clear; registers return to width 512, height 512, shifts 0.
// The slice memory is not cleared and holds undefined data until written.
module slice_translate_zero_fill #(
    parameter int MAX_WIDTH  = stzf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = stzf_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = stzf_pkg::PIXEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [stzf_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [stzf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  stzf_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output stzf_pkg::t_out_item                 o_out
);

    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = $clog2(DEPTH);
    localparam int OUT_BITS = stzf_pkg::PIX_BITS;

    // configuration registers
    logic [stzf_pkg::DIM_BITS-1:0]          r_cfg_width;
    logic [stzf_pkg::DIM_BITS-1:0]          r_cfg_height;
    logic signed [stzf_pkg::SHIFT_BITS-1:0] r_shift_x;
    logic signed [stzf_pkg::SHIFT_BITS-1:0] r_shift_y;

    // pipeline
    logic                                r_s1_valid;
    logic                                r_s1_op;
    stzf_pkg::t_coord                    r_s1_ax;
    stzf_pkg::t_coord                    r_s1_ay;
    logic                                r_s1_hit;
    logic [stzf_pkg::PIX_BITS-1:0]       r_s1_pix;
    logic                                r_s2_valid;
    logic                                r_s2_fetch;
    logic                                r_s2_hit;
    logic                                r_out_valid;
    stzf_pkg::t_out_item                 r_out;

    stzf_pkg::t_coord eff_w;
    stzf_pkg::t_coord eff_h;
    stzf_pkg::t_coord in_col;
    stzf_pkg::t_coord in_row;
    stzf_pkg::t_coord src_x;
    stzf_pkg::t_coord src_y;
    logic             fetch_inside;
    logic             store_inside;
    stzf_pkg::t_coord n_s1_ax;
    stzf_pkg::t_coord n_s1_ay;
    logic             n_s1_hit;
    stzf_pkg::t_out_item n_out;

    logic out_move;
    logic s2_move;
    logic s1_move;
    logic in_fire;

    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_addr;
    logic [PIXEL_BITS-1:0] ram_wdata;
    logic [PIXEL_BITS-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= stzf_pkg::DIM_RESET;
            r_cfg_height <= stzf_pkg::DIM_RESET;
            r_shift_x    <= stzf_pkg::SHIFT_RESET;
            r_shift_y    <= stzf_pkg::SHIFT_RESET;
        end else if (i_cfg_we) begin
            unique case (stzf_pkg::t_cfg_idx'(i_cfg_idx))
                stzf_pkg::CFG_SLICE_WIDTH:  r_cfg_width  <= i_cfg_data[stzf_pkg::DIM_BITS-1:0];
                stzf_pkg::CFG_SLICE_HEIGHT: r_cfg_height <= i_cfg_data[stzf_pkg::DIM_BITS-1:0];
                stzf_pkg::CFG_SHIFT_X:      r_shift_x    <= i_cfg_data;
                stzf_pkg::CFG_SHIFT_Y:      r_shift_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // offsets and bounds for the incoming beat
    always_comb begin
        eff_w  = (stzf_pkg::t_coord'(r_cfg_width) > stzf_pkg::t_coord'(MAX_WIDTH))
                 ? stzf_pkg::t_coord'(MAX_WIDTH) : stzf_pkg::t_coord'(r_cfg_width);
        eff_h  = (stzf_pkg::t_coord'(r_cfg_height) > stzf_pkg::t_coord'(MAX_HEIGHT))
                 ? stzf_pkg::t_coord'(MAX_HEIGHT) : stzf_pkg::t_coord'(r_cfg_height);
        in_col = stzf_pkg::t_coord'(i_in.col);
        in_row = stzf_pkg::t_coord'(i_in.row);
        src_x  = in_col - stzf_pkg::t_coord'(r_shift_x);
        src_y  = in_row - stzf_pkg::t_coord'(r_shift_y);

        fetch_inside = (in_col < eff_w) && (in_row < eff_h) &&
                       !src_x[stzf_pkg::COORD_BITS-1] && (src_x < eff_w) &&
                       !src_y[stzf_pkg::COORD_BITS-1] && (src_y < eff_h);
        store_inside = (in_col < stzf_pkg::t_coord'(MAX_WIDTH)) &&
                       (in_row < stzf_pkg::t_coord'(MAX_HEIGHT));

        if (i_in.opcode == stzf_pkg::OP_FETCH) begin
            n_s1_ax  = src_x;
            n_s1_ay  = src_y;
            n_s1_hit = fetch_inside;
        end else begin
            n_s1_ax  = in_col;
            n_s1_ay  = in_row;
            n_s1_hit = store_inside;
        end
    end

    // stall chain: a stage advances when it is empty or its successor moves; stage 2 also when it holds a store
    assign out_move   = !r_out_valid || i_out_ready;
    assign s2_move    = !r_s2_valid || !r_s2_fetch || out_move;
    assign s1_move    = !r_s1_valid || s2_move;
    assign o_in_ready = s1_move;
    assign in_fire    = i_in_valid && s1_move;

    // stores write and fetches read in the same stage, so program order holds
    assign ram_addr  = AW'($unsigned(r_s1_ay)) * AW'(MAX_WIDTH) + AW'($unsigned(r_s1_ax));
    assign ram_we    = s1_move && r_s1_valid && (r_s1_op == stzf_pkg::OP_STORE) && r_s1_hit;
    assign ram_re    = s1_move && r_s1_valid && (r_s1_op == stzf_pkg::OP_FETCH) && r_s1_hit;
    assign ram_wdata = PIXEL_BITS'(r_s1_pix);

    stzf_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_slice_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_out.pixel_out   = r_s2_hit ? OUT_BITS'(ram_rdata) : '0;
        n_out.from_source = r_s2_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_s1_valid <= in_fire;
            end
            if (s2_move) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_move) begin
                r_out_valid <= r_s2_valid && r_s2_fetch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op  <= i_in.opcode;
            r_s1_ax  <= n_s1_ax;
            r_s1_ay  <= n_s1_ay;
            r_s1_hit <= n_s1_hit;
            r_s1_pix <= i_in.pixel_in;
        end
        if (s2_move) begin
            r_s2_fetch <= r_s1_op == stzf_pkg::OP_FETCH;
            r_s2_hit   <= r_s1_hit;
        end
        if (out_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("slice RAM written and read in one cycle");

    a_read_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_fetch && !out_move) |-> !ram_re)
        else $error("slice RAM read issued while a fetch waits on its data");

    a_zero_fill_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.from_source) |-> (o_out.pixel_out == '0))
        else $error("zero-filled beat carries non-zero pixel");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_s2_valid && r_s2_fetch && r_out_valid))
        else $error("input stalled with a free pipeline slot");

    a_result_follows_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid && r_s2_fetch))
        else $error("result beat without a fetch behind it");
`endif

endmodule

// ===== rtl/core/stzf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stzf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
